### sv/pgs_pkg.sv
// Package for the parking gap scanner: phase codes, status codes, register indexes, helpers.
package pgs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SEEK    = 3'd1,
        PH_MEASURE = 3'd2,
        PH_JUDGE   = 3'd3,
        PH_FOUND   = 3'd4,
        PH_FAIL    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_FOUND = 2'd1,
        ST_FAIL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_TICK_MS    = 3'd0,
        CFG_MIN_GAP    = 3'd1,
        CFG_CAR_LENGTH = 3'd2,
        CFG_MAX_SCAN   = 3'd3,
        CFG_SLOT_WIDTH = 3'd4
    } t_cfg_idx;

    localparam int IN_BYTES  = 11;
    localparam int OUT_BYTES = 13;
    localparam int CFG_W     = 31;

    localparam logic [9:0]  TICK_MS_RST    = 10'd10;
    localparam logic [26:0] MIN_GAP_RST    = 27'd6000000;
    localparam logic [26:0] CAR_LENGTH_RST = 27'd4500000;
    localparam logic [30:0] MAX_SCAN_RST   = 31'd12000000;
    localparam logic [16:0] SLOT_WIDTH_RST = 17'd2500;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // clamp a 33-bit signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? S32_MIN : S32_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/parking_gap_scanner.sv
// Parking gap scanner: odometry integration and gap search state machine.
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | start_req[0] speed_mm_s[16:1] detected[17] pos_x_mm[49:18] pos_y_mm[81:50]
//  m_axis   | out | status[1:0] spot_length_um[33:2] spot_x_mm[65:34] spot_y_mm[97:66]
//  cfg      | in  | wr_en, addr 0..4, data 31 bits
//
// One transaction per cycle sustained while m_axis is not stalled; each result passes
// through the input register, which holds speed times tick period, and the result register.
// The scan step is combinational between the two, so state is updated per transaction in order.
// Synchronous active-low reset clears scan state and loads register defaults.
// A stalled result register holds the input stage; s_axis tready drops only when that happens.
module parking_gap_scanner
    import pgs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // start_req, speed_mm_s, detected, pos_x_mm, pos_y_mm, zero pad
    input  logic [IN_BYTES*8-1:0]    i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // status, spot_length_um, spot_x_mm, spot_y_mm, zero pad
    output logic [OUT_BYTES*8-1:0]   o_m_axis_tdata,
    input  logic                     i_cfg_wr_en,
    input  logic [2:0]               i_cfg_addr,
    input  logic [CFG_W-1:0]         i_cfg_wdata
);

    logic [9:0]  r_tick_ms;
    logic [26:0] r_min_gap;
    logic [26:0] r_car_len;
    logic [30:0] r_max_scan;
    logic [16:0] r_slot_w;

    logic                r_in_valid;
    logic                r_start;
    logic                r_det;
    logic signed [26:0]  r_step;
    logic signed [31:0]  r_px;
    logic signed [31:0]  r_py;

    t_phase              r_phase, n_phase;
    logic signed [31:0]  r_trav, n_trav;
    logic signed [31:0]  r_gap, n_gap;
    logic signed [31:0]  r_mark_x, n_mark_x;
    logic signed [31:0]  r_mark_y, n_mark_y;

    logic                r_out_valid;
    t_status             r_status, n_status;
    logic signed [31:0]  r_len, n_len;
    logic signed [31:0]  r_spot_y, n_spot_y;

    logic                w_adv;
    logic                w_in_acc;
    logic                w_step;
    logic signed [15:0]  w_speed;
    logic signed [26:0]  w_mul;
    t_phase              w_ph0;
    logic signed [31:0]  w_trav0;
    logic signed [31:0]  w_gap0;
    logic                w_gap_min;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_step          = r_in_valid && w_adv;

    assign w_speed = i_s_axis_tdata[16:1];
    assign w_mul   = w_speed * $signed({1'b0, r_tick_ms});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms  <= TICK_MS_RST;
            r_min_gap  <= MIN_GAP_RST;
            r_car_len  <= CAR_LENGTH_RST;
            r_max_scan <= MAX_SCAN_RST;
            r_slot_w   <= SLOT_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TICK_MS:    r_tick_ms  <= i_cfg_wdata[9:0];
                CFG_MIN_GAP:    r_min_gap  <= i_cfg_wdata[26:0];
                CFG_CAR_LENGTH: r_car_len  <= i_cfg_wdata[26:0];
                CFG_MAX_SCAN:   r_max_scan <= i_cfg_wdata[30:0];
                CFG_SLOT_WIDTH: r_slot_w   <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_start <= i_s_axis_tdata[0];
            r_step  <= w_mul;
            r_det   <= i_s_axis_tdata[17];
            r_px    <= i_s_axis_tdata[49:18];
            r_py    <= i_s_axis_tdata[81:50];
        end
    end

    // scan step
    always_comb begin
        w_ph0   = r_start ? PH_IDLE : r_phase;
        w_trav0 = r_start ? 32'sd0 : r_trav;
        w_gap0  = r_start ? 32'sd0 : r_gap;

        n_trav   = sat33(33'(w_trav0) + 33'(r_step));
        n_gap    = w_gap0;
        n_mark_x = r_mark_x;
        n_mark_y = r_mark_y;
        n_status = ST_BUSY;
        n_phase  = w_ph0;
        w_gap_min = w_gap0 >= $signed({5'd0, r_min_gap});

        if (n_trav >= $signed({1'b0, r_max_scan})) begin
            n_phase = PH_FAIL;
        end

        case (n_phase)
            PH_FAIL: begin
                n_status = ST_FAIL;
            end
            PH_SEEK: begin
                if (!r_det) begin
                    n_mark_x = r_px;
                    n_mark_y = r_py;
                    n_phase  = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                if (r_det || w_gap_min) begin
                    n_phase = PH_JUDGE;
                end
                n_gap = sat33(33'(w_gap0) + 33'(r_step));
            end
            PH_JUDGE: begin
                if (r_det && (w_gap0 <= $signed({5'd0, r_car_len}))) begin
                    n_phase = PH_SEEK;
                end else if (r_det || w_gap_min) begin
                    n_phase  = PH_FOUND;
                    n_status = ST_FOUND;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_FOUND: begin
                n_status = ST_FOUND;
            end
            default: begin
                n_gap   = 32'sd0;
                n_trav  = 32'sd0;
                n_phase = PH_SEEK;
            end
        endcase

        n_len    = (n_status == ST_FOUND) ? n_gap : 32'sd0;
        n_spot_y = sat33(33'(n_mark_y) - $signed({17'd0, r_slot_w[16:1]}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_trav   <= 32'sd0;
            r_gap    <= 32'sd0;
            r_mark_x <= 32'sd0;
            r_mark_y <= 32'sd0;
        end else if (w_step) begin
            r_phase  <= n_phase;
            r_trav   <= n_trav;
            r_gap    <= n_gap;
            r_mark_x <= n_mark_x;
            r_mark_y <= n_mark_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_status <= n_status;
            r_len    <= n_len;
            r_spot_y <= n_spot_y;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_spot_y, r_mark_x, r_len, r_status};

`ifndef NO_ASSERTIONS
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> ($stable(r_phase) && $stable(r_trav) && $stable(r_gap)))
        else $error("scan state changed while result stalled");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_FOUND) |-> (r_len == 32'sd0))
        else $error("spot length nonzero without found status");

    a_found_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FOUND) |-> (r_phase == PH_FOUND))
        else $error("found status without found phase");

    a_fail_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FAIL) |-> (r_phase == PH_FAIL))
        else $error("fail status without fail phase");
`endif

endmodule

### dv/tb.sv
// Testbench for parking_gap_scanner: directed and random ticks checked against a scan predictor.
`timescale 1ns / 1ps

module tb
    import pgs_pkg::*;
();

    typedef struct packed {
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic               detected;
        logic signed [15:0] speed;
        logic               start;
    } tick_t;

    typedef struct packed {
        logic signed [31:0] spot_y;
        logic signed [31:0] spot_x;
        logic signed [31:0] spot_len;
        t_status            status;
    } report_t;

    typedef struct {
        logic [9:0]  tick_ms;
        logic [26:0] min_gap_um;
        logic [26:0] car_length_um;
        logic [30:0] max_scan_um;
        logic [16:0] slot_width_mm;
    } scan_cfg_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    tick_t                s_tick = '0;
    logic                 m_ready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_addr = CFG_TICK_MS;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [OUT_BYTES*8-1:0] o_m_axis_tdata;

    report_t   pending_reports[$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        out_stall = 0;
    bit        in_idle_on = 1'b1;
    bit        out_idle_on = 1'b1;

    // predictor copy of the block
    scan_cfg_t cfg_now = '{TICK_MS_RST, MIN_GAP_RST, CAR_LENGTH_RST, MAX_SCAN_RST,
                           SLOT_WIDTH_RST};
    t_phase    scan_ph = PH_IDLE;
    int        travel_um = 0;
    int        gap_acc_um = 0;
    int        mark_x = 0;
    int        mark_y = 0;

    parking_gap_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  ({6'd0, s_tick}),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int clamp_s32(input longint v);
        if (v > longint'(S32_MAX)) begin
            return S32_MAX;
        end
        if (v < longint'(S32_MIN)) begin
            return S32_MIN;
        end
        return int'(v);
    endfunction

    function automatic report_t predict_scan(input tick_t t);
        report_t r;
        longint  stride;
        stride = longint'(t.speed) * longint'(cfg_now.tick_ms);
        r = '0;
        r.status = ST_BUSY;
        if (t.start) begin
            scan_ph = PH_IDLE;
            travel_um = 0;
            gap_acc_um = 0;
        end
        travel_um = clamp_s32(longint'(travel_um) + stride);
        if (longint'(travel_um) >= longint'(cfg_now.max_scan_um)) begin
            scan_ph = PH_FAIL;
        end
        case (scan_ph)
            PH_FAIL: begin
                r.status = ST_FAIL;
            end
            PH_SEEK: begin
                if (!t.detected) begin
                    mark_x = t.pos_x;
                    mark_y = t.pos_y;
                    scan_ph = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                if (t.detected || longint'(gap_acc_um) >= longint'(cfg_now.min_gap_um)) begin
                    scan_ph = PH_JUDGE;
                end
                gap_acc_um = clamp_s32(longint'(gap_acc_um) + stride);
            end
            PH_JUDGE: begin
                if (t.detected && longint'(gap_acc_um) <= longint'(cfg_now.car_length_um)) begin
                    scan_ph = PH_SEEK;
                end else if (t.detected ||
                             longint'(gap_acc_um) >= longint'(cfg_now.min_gap_um)) begin
                    scan_ph = PH_FOUND;
                    r.status = ST_FOUND;
                end else begin
                    scan_ph = PH_IDLE;
                end
            end
            PH_FOUND: begin
                r.status = ST_FOUND;
            end
            default: begin
                gap_acc_um = 0;
                travel_um = 0;
                scan_ph = PH_SEEK;
            end
        endcase
        r.spot_len = (r.status == ST_FOUND) ? gap_acc_um : 0;
        r.spot_x = mark_x;
        r.spot_y = clamp_s32(longint'(mark_y) - longint'(cfg_now.slot_width_mm / 2));
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        report_t got;
        report_t want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got = o_m_axis_tdata[97:0];
            if (pending_reports.size() == 0) begin
                $error("unexpected result transaction, status %0d", got.status);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("status", longint'(want.status), longint'(got.status));
                check_field("spot_length_um", longint'(want.spot_len), longint'(got.spot_len));
                check_field("spot_x_mm", longint'(want.spot_x), longint'(got.spot_x));
                check_field("spot_y_mm", longint'(want.spot_y), longint'(got.spot_y));
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
            out_stall = $urandom_range(1, 14) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic tick_t make_tick(input bit st, input bit det, input int spd);
        tick_t t;
        t.start = st;
        t.detected = det;
        t.speed = 16'(spd);
        t.pos_x = $urandom;
        t.pos_y = $urandom;
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tick <= t;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_reports.push_back(predict_scan(t));
        items_sent++;
    endtask

    task automatic drain_reports();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input scan_cfg_t c);
        drain_reports();
        put_reg(CFG_TICK_MS, CFG_W'(c.tick_ms));
        put_reg(CFG_MIN_GAP, CFG_W'(c.min_gap_um));
        put_reg(CFG_CAR_LENGTH, CFG_W'(c.car_length_um));
        put_reg(CFG_MAX_SCAN, CFG_W'(c.max_scan_um));
        put_reg(CFG_SLOT_WIDTH, CFG_W'(c.slot_width_mm));
        cfg_we <= 1'b0;
        cfg_now = c;
        @(posedge i_clk);
    endtask

    // directed setting: 20000 um per tick at speed 2000
    localparam scan_cfg_t DIRECTED_CFG = '{10'd10, 27'd100000, 27'd50000, 31'd1000000,
                                           17'd2500};

    task automatic test_found_by_car();
        send_tick(make_tick(1, 1, 2000));
        send_tick(make_tick(0, 0, 2000));
        repeat (3) send_tick(make_tick(0, 0, 2000));
        send_tick(make_tick(0, 1, 2000));
        send_tick(make_tick(0, 1, 2000));
        send_tick(make_tick(0, 0, 2000));
    endtask

    // short gap ended by a car goes back to seeking, the next gap adds on
    task automatic test_rejected_gap();
        send_tick(make_tick(1, 1, 2000));
        send_tick(make_tick(0, 0, 2000));
        send_tick(make_tick(0, 0, 2000));
        send_tick(make_tick(0, 1, 2000));
        send_tick(make_tick(0, 1, 2000));
        send_tick(make_tick(0, 0, 2000));
        send_tick(make_tick(0, 1, 2000));
        send_tick(make_tick(0, 1, 2000));
    endtask

    task automatic test_short_gap_no_car();
        send_tick(make_tick(1, 1, 2000));
        send_tick(make_tick(0, 0, 2000));
        send_tick(make_tick(0, 1, 2000));
        send_tick(make_tick(0, 0, 2000));
        send_tick(make_tick(0, 1, 2000));
    endtask

    task automatic test_long_gap_then_limit();
        send_tick(make_tick(1, 1, 2000));
        repeat (9) send_tick(make_tick(0, 0, 2000));
        drain_reports();
        // found is overridden once travel passes the limit
        repeat (4) send_tick(make_tick(0, 0, 32767));
        send_tick(make_tick(1, 1, -32768));
        send_tick(make_tick(0, 1, 0));
    endtask

    task automatic test_corner_extremes();
        scan_cfg_t c;
        tick_t t;
        c = DIRECTED_CFG;
        c.slot_width_mm = 17'd100000;
        load_setting(c);
        send_tick(make_tick(1, 1, 1));
        t = make_tick(0, 0, 1);
        t.pos_x = S32_MAX;
        t.pos_y = S32_MIN;
        send_tick(t);
        c.slot_width_mm = 17'd99999;
        load_setting(c);
        send_tick(make_tick(1, 1, 0));
        t = make_tick(0, 0, 0);
        t.pos_x = S32_MIN;
        t.pos_y = S32_MAX;
        send_tick(t);
    endtask

    function automatic int pick_speed();
        longint thr;
        longint s;
        thr = (cfg_now.min_gap_um > cfg_now.car_length_um) ? cfg_now.min_gap_um
                                                            : cfg_now.car_length_um;
        if (thr == 0) begin
            return $urandom_range(1, 2000);
        end
        s = thr / $urandom_range(3, 10) / longint'(cfg_now.tick_ms);
        if (s < 1) begin
            s = 1;
        end
        if (s > 32767) begin
            s = 32767;
        end
        return int'(s);
    endfunction

    function automatic int jitter(input int spd);
        int s;
        s = spd * $urandom_range(75, 125) / 100;
        return (s > 32767) ? 32767 : s;
    endfunction

    task automatic run_episode();
        int spd;
        spd = pick_speed();
        send_tick(make_tick(1, 1, spd));
        repeat ($urandom_range(0, 3)) send_tick(make_tick(0, 1, jitter(spd)));
        repeat ($urandom_range(1, 2)) begin
            repeat ($urandom_range(1, 12)) send_tick(make_tick(0, 0, jitter(spd)));
            repeat ($urandom_range(0, 4)) send_tick(make_tick(0, 1, jitter(spd)));
        end
        repeat ($urandom_range(0, 3)) begin
            send_tick(make_tick(0, $urandom_range(0, 1), jitter(spd)));
        end
    endtask

    // long reverse run: travel and gap run negative, saturating at the negative limit for long tick periods
    task automatic run_reverse();
        send_tick(make_tick(1, 1, 0));
        send_tick(make_tick(0, 0, -32768));
        repeat (70) send_tick(make_tick(0, 0, -32768));
    endtask

    task automatic run_noise();
        tick_t t;
        repeat ($urandom_range(1, 8)) begin
            t = make_tick($urandom_range(0, 7) == 0, $urandom_range(0, 1), $urandom);
            send_tick(t);
        end
    endtask

    task automatic run_random(input int n);
        int stop_at;
        int pick;
        stop_at = items_sent + n;
        if (cfg_now.tick_ms >= 10'd500) begin
            run_reverse();
        end
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                run_episode();
            end else if (pick < 92) begin
                run_noise();
            end else if (pick < 97) begin
                repeat (40) send_tick(make_tick(0, $urandom_range(0, 1),
                                                $urandom_range(20000, 32767)));
            end else begin
                run_reverse();
            end
        end
    endtask

    task automatic test_random_settings();
        scan_cfg_t c;
        load_setting('{10'd1000, 27'd100000000, 27'd100000000, 31'd2000000000, 17'd100000});
        run_random(110);
        load_setting('{10'd1, 27'd0, 27'd0, 31'd0, 17'd0});
        run_random(110);
        load_setting('{TICK_MS_RST, MIN_GAP_RST, CAR_LENGTH_RST, MAX_SCAN_RST, SLOT_WIDTH_RST});
        run_random(110);
        repeat (3) begin
            c.tick_ms = 10'($urandom_range(1, 1000));
            c.min_gap_um = 27'($urandom_range(0, 100000000));
            c.car_length_um = 27'($urandom_range(0, 100000000));
            c.max_scan_um = 31'($urandom_range(0, 2000000000));
            c.slot_width_mm = 17'($urandom_range(0, 100000));
            if (!in_idle_on || $urandom_range(0, 1) == 0) begin
                c.car_length_um = 27'(longint'(c.min_gap_um) * $urandom_range(50, 90) / 100);
                c.max_scan_um = 31'(longint'(c.min_gap_um) * $urandom_range(2, 15));
            end
            load_setting(c);
            run_random(110);
            if (c.tick_ms[0]) begin
                in_idle_on = 1'b0;
                out_idle_on = 1'b0;
            end
        end
        // final stretch runs without idling
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        load_setting('{10'd25, 27'd400000, 27'd250000, 31'd3000000, 17'd1801});
        run_random(60);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_setting(DIRECTED_CFG);
        test_found_by_car();
        test_rejected_gap();
        test_short_gap_no_car();
        test_long_gap_then_limit();
        test_corner_extremes();
        test_random_settings();
        drain_reports();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
